// ===== design/erq_pkg.sv =====
// Package for the elevator request queues: operation codes, sequencer states
// and the packed request, result and queue command types.
// No dependencies.
package erq_pkg;

	localparam int FLOOR_W = 4;
	localparam int OP_W    = 2;

	localparam logic [OP_W-1:0] OP_HALL   = 2'd0;
	localparam logic [OP_W-1:0] OP_CABIN  = 2'd1;
	localparam logic [OP_W-1:0] OP_ARRIVE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_FINISH
	} erq_state_t;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic               queue_dir;
		logic [FLOOR_W-1:0] floor;
		logic [FLOOR_W-1:0] cur_floor;
		logic               door_open;
	} erq_req_t;

	typedef struct packed {
		logic [FLOOR_W-1:0] target_floor;
		logic               going_up;
		logic               all_empty;
		logic               open_request;
		logic               arrived;
		logic               ignored;
	} erq_res_t;

	typedef struct packed {
		logic               ins;
		logic               pop;
		logic [FLOOR_W-1:0] val;
	} erq_qop_t;

endpackage

// ===== design/erq_queue.sv =====
// One sorted floor request queue: slot read port, insert with shift toward
// the tail, and pop from the head. Depends on erq_pkg.
module erq_queue import erq_pkg::*; #(
	parameter int NUM_FLOORS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  erq_qop_t                      op,
	input  logic [$clog2(NUM_FLOORS)-1:0] idx,
	output logic [FLOOR_W-1:0]            rd_data,
	output logic [FLOOR_W-1:0]            head
);

	localparam int IW = $clog2(NUM_FLOORS);

	logic [FLOOR_W-1:0] slot_q [NUM_FLOORS];

	assign rd_data = slot_q[idx];
	assign head    = slot_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_FLOORS; j++) begin
				slot_q[j] <= '0;
			end
		end else if (op.ins) begin
			for (int j = 0; j < NUM_FLOORS; j++) begin
				if (IW'(j) == idx) begin
					slot_q[j] <= op.val;
				end else if (j > 0 && IW'(j) > idx) begin
					slot_q[j] <= slot_q[j-1];
				end
			end
		end else if (op.pop) begin
			for (int j = 0; j < NUM_FLOORS - 1; j++) begin
				slot_q[j] <= slot_q[j+1];
			end
			slot_q[NUM_FLOORS-1] <= '0;
		end
	end

endmodule

// ===== design/elevator_request_queues.sv =====
// Elevator request queues, top level: sequencer around one shared floor comparator.
// Sequence: the transfer is captured, then DECODE and, for a queued call, SCAN with one
// comparator step per scanned slot, then FINISH; the result strobe is registered from FINISH.
// Throughput: one item at a time; busy stays high until the result strobe cycle.
// Reset: asynchronous, clears both queues, direction to down and the empty flag to one.
// Depends on erq_pkg and erq_queue.
module elevator_request_queues import erq_pkg::*; #(
	parameter int NUM_FLOORS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  erq_req_t request,
	output logic     busy,
	output logic     done,
	output erq_res_t result
);

	localparam int IW = $clog2(NUM_FLOORS);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_FLOORS - 1);
	localparam logic [FLOOR_W-1:0] TOP_FLOOR = FLOOR_W'(NUM_FLOORS);

	erq_state_t state_q, state_d;
	erq_req_t   req_q;
	logic       sel_up_q, sel_up_d;
	logic [IW-1:0] idx_q, idx_d;
	logic       open_q, open_d, arr_q, arr_d, ign_q, ign_d;
	logic       travel_up_q, empty_q;
	logic       done_q;
	erq_res_t   result_q;

	erq_qop_t up_op, dn_op;
	logic [FLOOR_W-1:0] up_rd, dn_rd, up_head, dn_head;
	logic [FLOOR_W-1:0] slot, act_head;
	logic fl_ok, hit, place, up_e, dn_e, travel_d;

	erq_queue #(.NUM_FLOORS(NUM_FLOORS)) u_up (
		.clk(clk), .arst_n(arst_n), .op(up_op), .idx(idx_q),
		.rd_data(up_rd), .head(up_head)
	);

	erq_queue #(.NUM_FLOORS(NUM_FLOORS)) u_dn (
		.clk(clk), .arst_n(arst_n), .op(dn_op), .idx(idx_q),
		.rd_data(dn_rd), .head(dn_head)
	);

	assign slot     = sel_up_q ? up_rd : dn_rd;
	assign hit      = (slot == req_q.floor);
	assign place    = (slot == '0) ||
		(sel_up_q ? (req_q.floor < slot) : (req_q.floor > slot));
	assign fl_ok    = (req_q.floor != '0) && (req_q.floor <= TOP_FLOOR);
	assign act_head = travel_up_q ? up_head : dn_head;
	assign up_e     = (up_head == '0);
	assign dn_e     = (dn_head == '0);
	assign travel_d = up_e ? 1'b0 : (dn_e ? 1'b1 : travel_up_q);

	always_comb begin
		state_d  = state_q;
		sel_up_d = sel_up_q;
		idx_d    = idx_q;
		open_d   = open_q;
		arr_d    = arr_q;
		ign_d    = ign_q;
		up_op    = '{ins: 1'b0, pop: 1'b0, val: req_q.floor};
		dn_op    = '{ins: 1'b0, pop: 1'b0, val: req_q.floor};
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DECODE;
					open_d  = 1'b0;
					arr_d   = 1'b0;
					ign_d   = 1'b0;
				end
			end
			ST_DECODE: begin
				state_d = ST_FINISH;
				idx_d   = '0;
				case (req_q.operation)
					OP_HALL: begin
						if (!fl_ok) begin
							ign_d = 1'b1;
						end else begin
							sel_up_d = req_q.queue_dir;
							state_d  = ST_SCAN;
						end
					end
					OP_CABIN: begin
						if (!fl_ok) begin
							ign_d = 1'b1;
						end else if (req_q.floor < req_q.cur_floor) begin
							sel_up_d = 1'b0;
							state_d  = ST_SCAN;
						end else if (req_q.floor > req_q.cur_floor) begin
							sel_up_d = 1'b1;
							state_d  = ST_SCAN;
						end else begin
							open_d = !req_q.door_open && empty_q;
						end
					end
					OP_ARRIVE: begin
						if (!empty_q && act_head != '0 && act_head == req_q.cur_floor) begin
							arr_d     = 1'b1;
							open_d    = 1'b1;
							up_op.pop = travel_up_q;
							dn_op.pop = !travel_up_q;
						end
					end
					default: begin
					end
				endcase
			end
			ST_SCAN: begin
				if (hit) begin
					ign_d   = 1'b1;
					state_d = ST_FINISH;
				end else if (place) begin
					up_op.ins = sel_up_q;
					dn_op.ins = !sel_up_q;
					state_d   = ST_FINISH;
				end else if (idx_q == LAST_IDX) begin
					state_d = ST_FINISH;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_up_q    <= 1'b0;
			idx_q       <= '0;
			open_q      <= 1'b0;
			arr_q       <= 1'b0;
			ign_q       <= 1'b0;
			travel_up_q <= 1'b0;
			empty_q     <= 1'b1;
			done_q      <= 1'b0;
		end else begin
			state_q  <= state_d;
			sel_up_q <= sel_up_d;
			idx_q    <= idx_d;
			open_q   <= open_d;
			arr_q    <= arr_d;
			ign_q    <= ign_d;
			done_q   <= (state_q == ST_FINISH);
			if (state_q == ST_FINISH) begin
				travel_up_q <= travel_d;
				empty_q     <= up_e && dn_e;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q <= request;
		end
		if (state_q == ST_FINISH) begin
			result_q.target_floor <= travel_d ? up_head : dn_head;
			result_q.going_up     <= travel_d;
			result_q.all_empty    <= up_e && dn_e;
			result_q.open_request <= open_q;
			result_q.arrived      <= arr_q;
			result_q.ignored      <= ign_q;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("transfer did not start the sequencer");
	a_arrive_open: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.arrived |-> result.open_request)
		else $error("arrival without door open request");
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.all_empty |-> result.target_floor == '0 && !result.going_up)
		else $error("empty queues with a target or upward travel");
`endif

endmodule

// ===== test/tb_elevator_request_queues.sv =====
// Self-checking testbench for elevator_request_queues: a directed table, then three
// random phases with varying sender gaps, checked against a floor queue predictor.
// Depends on erq_pkg and the elevator_request_queues RTL.
module tb_elevator_request_queues import erq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_FLOORS     = 8;
	localparam int DIRECTED_N     = 25;
	localparam int PHASE_ITEMS    = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = NUM_FLOORS + 8;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic DIR_DOWN = 1'b0;
	localparam logic DIR_UP   = 1'b1;

	localparam erq_res_t IDLE_RES = '{4'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
	localparam erq_res_t OPEN_RES = '{4'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
	localparam erq_res_t IGN_RES  = '{4'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
	localparam erq_res_t NO_RES   = '0;

	typedef logic [NUM_FLOORS-1:0][FLOOR_W-1:0] floor_list_t;

	typedef struct {
		erq_req_t req;
		bit       typed;
		erq_res_t res;
	} plan_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	erq_req_t request = '0;
	logic     busy;
	logic     done;
	erq_res_t result;

	floor_list_t up_list = '0;
	floor_list_t down_list = '0;
	bit          travel_up = 1'b0;
	bit          lists_empty = 1'b1;
	logic [3:0]  car_floor = 4'd1;

	erq_res_t awaited_outcomes [$];
	bit       typed_row = 1'b0;
	erq_res_t typed_res = '0;
	int       idle_pct = 10;
	int       mismatches = 0;
	int       transfers = 0;
	int       results_seen = 0;
	int       served = 0;
	int       opens = 0;
	int       ignored_calls = 0;
	int       idle_cycles = 0;

	plan_row_t plan [DIRECTED_N] = '{
		'{'{OP_ARRIVE, DIR_DOWN, 4'd0, 4'd1, 1'b0}, 1'b1, IDLE_RES},
		'{'{OP_CABIN, DIR_DOWN, 4'd3, 4'd3, 1'b0}, 1'b1, OPEN_RES},
		'{'{OP_CABIN, DIR_DOWN, 4'd3, 4'd3, 1'b1}, 1'b1, IDLE_RES},
		'{'{OP_HALL, DIR_UP, 4'd0, 4'd4, 1'b0}, 1'b1, IGN_RES},
		'{'{OP_HALL, DIR_DOWN, 4'd15, 4'd4, 1'b0}, 1'b1, IGN_RES},
		'{'{OP_CABIN, DIR_DOWN, 4'd9, 4'd2, 1'b0}, 1'b1, IGN_RES},
		'{'{OP_UNUSED, DIR_UP, 4'd5, 4'd5, 1'b0}, 1'b1, IDLE_RES},
		'{'{OP_HALL, DIR_UP, 4'd8, 4'd1, 1'b0}, 1'b0, NO_RES},
		'{'{OP_HALL, DIR_UP, 4'd1, 4'd1, 1'b0}, 1'b0, NO_RES},
		'{'{OP_HALL, DIR_UP, 4'd8, 4'd1, 1'b0}, 1'b0, NO_RES},
		'{'{OP_HALL, DIR_DOWN, 4'd1, 4'd1, 1'b0}, 1'b0, NO_RES},
		'{'{OP_HALL, DIR_DOWN, 4'd8, 4'd1, 1'b0}, 1'b0, NO_RES},
		'{'{OP_CABIN, DIR_DOWN, 4'd5, 4'd2, 1'b0}, 1'b0, NO_RES},
		'{'{OP_CABIN, DIR_DOWN, 4'd2, 4'd6, 1'b1}, 1'b0, NO_RES},
		'{'{OP_CABIN, DIR_DOWN, 4'd4, 4'd4, 1'b0}, 1'b0, NO_RES},
		'{'{OP_ARRIVE, DIR_DOWN, 4'd0, 4'd1, 1'b0}, 1'b0, NO_RES},
		'{'{OP_ARRIVE, DIR_DOWN, 4'd0, 4'd7, 1'b0}, 1'b0, NO_RES},
		'{'{OP_ARRIVE, DIR_DOWN, 4'd0, 4'd5, 1'b1}, 1'b0, NO_RES},
		'{'{OP_ARRIVE, DIR_DOWN, 4'd0, 4'd8, 1'b0}, 1'b0, NO_RES},
		'{'{OP_ARRIVE, DIR_DOWN, 4'd0, 4'd8, 1'b0}, 1'b0, NO_RES},
		'{'{OP_ARRIVE, DIR_DOWN, 4'd0, 4'd2, 1'b0}, 1'b0, NO_RES},
		'{'{OP_ARRIVE, DIR_DOWN, 4'd0, 4'd1, 1'b1}, 1'b0, NO_RES},
		'{'{OP_CABIN, DIR_DOWN, 4'd8, 4'd15, 1'b0}, 1'b0, NO_RES},
		'{'{OP_CABIN, DIR_DOWN, 4'd1, 4'd0, 1'b0}, 1'b0, NO_RES},
		'{'{OP_UNUSED, DIR_DOWN, 4'd0, 4'd0, 1'b0}, 1'b0, NO_RES}
	};

	elevator_request_queues #(
		.NUM_FLOORS(NUM_FLOORS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	function automatic floor_list_t list_insert(input floor_list_t q, input logic [3:0] f,
			input bit ascending, output bit dup);
		floor_list_t r;
		bit          placed;
		r = q;
		dup = 1'b0;
		placed = 1'b0;
		for (int i = 0; i < NUM_FLOORS && !placed && !dup; i++) begin
			if (q[i] == f) begin
				dup = 1'b1;
			end else if (q[i] == 0 || (ascending ? (f < q[i]) : (f > q[i]))) begin
				for (int j = NUM_FLOORS - 1; j > i; j--)
					r[j] = q[j-1];
				r[i] = f;
				placed = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic erq_res_t schedule_step(input erq_req_t r);
		erq_res_t   res;
		bit         dup;
		bit         floor_ok;
		bit         up_e;
		bit         dn_e;
		logic [3:0] head;
		res = '0;
		dup = 1'b0;
		floor_ok = (r.floor >= 1 && r.floor <= NUM_FLOORS);
		case (r.operation)
			OP_HALL: begin
				if (!floor_ok)
					dup = 1'b1;
				else if (r.queue_dir == DIR_UP)
					up_list = list_insert(up_list, r.floor, 1'b1, dup);
				else
					down_list = list_insert(down_list, r.floor, 1'b0, dup);
				res.ignored = dup;
			end
			OP_CABIN: begin
				if (!floor_ok)
					dup = 1'b1;
				else if (r.floor < r.cur_floor)
					down_list = list_insert(down_list, r.floor, 1'b0, dup);
				else if (r.floor > r.cur_floor)
					up_list = list_insert(up_list, r.floor, 1'b1, dup);
				else if (!r.door_open && lists_empty)
					res.open_request = 1'b1;
				res.ignored = dup;
			end
			OP_ARRIVE: begin
				if (!lists_empty) begin
					head = travel_up ? up_list[0] : down_list[0];
					if (head != 0 && head == r.cur_floor) begin
						res.arrived = 1'b1;
						res.open_request = 1'b1;
						if (travel_up)
							up_list = up_list >> FLOOR_W;
						else
							down_list = down_list >> FLOOR_W;
					end
				end
			end
			default: ;
		endcase
		up_e = (up_list == '0);
		dn_e = (down_list == '0);
		lists_empty = up_e && dn_e;
		if (up_e)
			travel_up = 1'b0;
		else if (dn_e)
			travel_up = 1'b1;
		res.target_floor = travel_up ? up_list[0] : down_list[0];
		res.going_up = travel_up;
		res.all_empty = lists_empty;
		return res;
	endfunction

	// Mostly calls at the car position and arrivals at the current head, some noise.
	function automatic erq_req_t draw_request();
		erq_req_t   r;
		int         pick;
		logic [3:0] head;
		pick = $urandom_range(99);
		head = travel_up ? up_list[0] : down_list[0];
		if ($urandom_range(9) == 0)
			car_floor = 4'($urandom_range(NUM_FLOORS, 1));
		r.queue_dir = 1'($urandom_range(1));
		r.door_open = 1'($urandom_range(1));
		r.floor = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
			: 4'($urandom_range(NUM_FLOORS, 1));
		r.cur_floor = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : car_floor;
		if (pick < 35) begin
			r.operation = OP_HALL;
		end else if (pick < 60) begin
			r.operation = OP_CABIN;
		end else if (pick < 96) begin
			r.operation = OP_ARRIVE;
			if (head != 0 && $urandom_range(3) != 0) begin
				car_floor = head;
				r.cur_floor = head;
			end
		end else begin
			r.operation = OP_UNUSED;
		end
		return r;
	endfunction

	task automatic send_request(input erq_req_t r, input bit has_typed, input erq_res_t typed);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		typed_row = has_typed;
		typed_res = typed;
		request <= r;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic check_result(input erq_res_t got);
		erq_res_t want;
		results_seen++;
		served += got.arrived;
		opens += got.open_request;
		ignored_calls += got.ignored;
		if (awaited_outcomes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result with nothing outstanding: %p", $realtime, got);
		end else begin
			want = awaited_outcomes.pop_front();
			if (got.target_floor !== want.target_floor || got.going_up !== want.going_up
					|| got.all_empty !== want.all_empty
					|| got.open_request !== want.open_request
					|| got.arrived !== want.arrived || got.ignored !== want.ignored) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result mismatch: expected %p, got %p", $realtime, want, got);
			end
		end
	endtask

	always @(posedge clk) begin
		erq_res_t predicted;
		if (arst_n) begin
			if (done)
				check_result(result);
			if (start && !busy) begin
				predicted = schedule_step(request);
				awaited_outcomes.push_back(typed_row ? typed_res : predicted);
				transfers++;
			end
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("tb_elevator_request_queues NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int phase_gap [3];
		phase_gap = '{10, 79, 0};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (plan[k])
			send_request(plan[k].req, plan[k].typed, plan[k].res);
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = phase_gap[ph];
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_request(draw_request(), 1'b0, NO_RES);
		end
		@(negedge clk);
		start <= 1'b0;
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests (%0d directed) and %0d results over gap rates 10/79/0%%",
			transfers, DIRECTED_N, results_seen);
		$display("served arrivals %0d, door opens %0d, ignored calls %0d, mismatches %0d",
			served, opens, ignored_calls, mismatches);
		if (mismatches == 0 && awaited_outcomes.size() == 0) begin
			$display("tb_elevator_request_queues OK");
		end else begin
			$display("tb_elevator_request_queues NOT OK");
		end
		$finish;
	end

endmodule
